// ===== rtl/wes_pkg.sv =====
// Shared constants and register index codes for the wireframe edge shader.
// No dependencies; imported by every module of the block.
package wes_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int CHANNEL_BITS    = 16;

  localparam int COORD_W   = 24;
  localparam int GRID_W    = 8;
  localparam int SCALE_W   = 24;
  localparam int COLOR_W   = 64;
  localparam int SLOT_W    = 16;
  localparam int NUM_CHAN  = 4;
  localparam int W_FRAC    = 16;
  localparam int W_BITS    = W_FRAC + 1;
  localparam int W_ONE     = 1 << W_FRAC;
  localparam int CFG_IDX_W = 3;

  localparam logic [COLOR_W-1:0] EDGE_COLOR_RST = 64'd65535;
  localparam logic [COLOR_W-1:0] FACE_COLOR_RST = 64'd0;
  localparam logic [SCALE_W-1:0] EDGE_SCALE_RST = 24'd1310720;
  localparam logic [GRID_W-1:0]  CELL_DIV_RST   = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EDGE_COLOR  = 3'd0,
    CFG_FACE_COLOR  = 3'd1,
    CFG_EDGE_SCALE  = 3'd2,
    CFG_CELL_DIV    = 3'd3,
    CFG_VOLUME_MODE = 3'd4
  } cfg_idx_e;

endpackage

// ===== rtl/wes_edge_dist.sv =====
// Edge distance of one reference coordinate: fraction of the coordinate times the
// cell subdivision count, folded at 0.5. Depends on wes_pkg.
module wes_fold_gap import wes_pkg::*; (
  input  logic [COORD_W-1:0]         coord_i,
  input  logic [GRID_W-1:0]          cell_div_i,
  output logic [COORD_FRAC_BITS-1:0] dist_o
);

  logic [COORD_FRAC_BITS+GRID_W-1:0] prod;
  logic [COORD_FRAC_BITS-1:0]        frac;

  assign prod = (COORD_FRAC_BITS+GRID_W)'(coord_i[COORD_FRAC_BITS-1:0])
              * (COORD_FRAC_BITS+GRID_W)'(cell_div_i);
  assign frac = prod[COORD_FRAC_BITS-1:0];
  // fold the upper half back: one - f taken modulo one
  assign dist_o = frac[COORD_FRAC_BITS-1] ? (~frac + 1'b1) : frac;

endmodule

// ===== rtl/wireframe_edge_shader.sv =====
// Wireframe edge shader top level: configuration registers and the shading pipeline.
// Depends on wes_pkg and wes_fold_gap.

// Seven-stage pipeline taking one hit item per clock while the output is not
// stalled; an item's RGBA result leaves from the register of the last stage.
// Stages: edge distances, minimum or median, scaled distance with clamp,
// (1-x)^2 and 1+2x, weight, channel products, rounded sum. Every stage has
// its own valid bit and moves whenever it is empty or the stage after it
// moves, so stalls on the output fill bubbles first and only then hold the
// input. Configuration is sampled by the stages as items pass, so write it
// only while the pipeline is empty.
module wireframe_edge_shader import wes_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COLOR_W-1:0]   cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // coord_u [23:0], coord_v [47:24], coord_w [71:48]
  input  logic [3*COORD_W-1:0] s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // red [15:0], green [31:16], blue [47:32], alpha [63:48]
  output logic [NUM_CHAN*SLOT_W-1:0] m_axis_tdata_o
);

  localparam int NSTG  = 7;
  localparam int DW    = COORD_FRAC_BITS;
  localparam int XP_W  = DW + SCALE_W;
  localparam int AA_W  = 2 * W_FRAC + 1;
  localparam int T_W   = W_BITS + 1;
  localparam int WP_W  = AA_W + T_W;
  localparam int P_W   = CHANNEL_BITS + W_BITS;
  localparam int S_W   = P_W + 1;

  logic [COLOR_W-1:0] edge_color_q;
  logic [COLOR_W-1:0] face_color_q;
  logic [SCALE_W-1:0] edge_scale_q;
  logic [GRID_W-1:0]  cell_div_q;
  logic               volume_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_color_q  <= EDGE_COLOR_RST;
      face_color_q  <= FACE_COLOR_RST;
      edge_scale_q  <= EDGE_SCALE_RST;
      cell_div_q    <= CELL_DIV_RST;
      volume_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_EDGE_COLOR:  edge_color_q  <= cfg_wdata_i;
        CFG_FACE_COLOR:  face_color_q  <= cfg_wdata_i;
        CFG_EDGE_SCALE:  edge_scale_q  <= cfg_wdata_i[SCALE_W-1:0];
        CFG_CELL_DIV:    cell_div_q    <= cfg_wdata_i[GRID_W-1:0];
        CFG_VOLUME_MODE: volume_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 0: edge distances
  logic [DW-1:0] dist_d [3];
  logic [DW-1:0] dist_q [3];

  for (genvar g = 0; g < 3; g++) begin : g_dist
    wes_fold_gap u_dist (
      .coord_i    (s_axis_tdata_i[g*COORD_W +: COORD_W]),
      .cell_div_i (cell_div_q),
      .dist_o     (dist_d[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) dist_q[k] <= dist_d[k];
    end
  end

  // stage 1: minimum of two, or median of three
  logic [DW-1:0] lo, hi, dsel_d, dsel_q;

  always_comb begin
    lo = (dist_q[0] < dist_q[1]) ? dist_q[0] : dist_q[1];
    hi = (dist_q[0] < dist_q[1]) ? dist_q[1] : dist_q[0];
    if (!volume_mode_q) begin
      dsel_d = lo;
    end else if (dist_q[2] < lo) begin
      dsel_d = lo;
    end else if (hi < dist_q[2]) begin
      dsel_d = hi;
    end else begin
      dsel_d = dist_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) dsel_q <= dsel_d;
  end

  // stage 2: x = d * edge_scale, clamped to one
  logic [XP_W-1:0]    xprod;
  logic [SCALE_W-1:0] xraw;
  logic [W_BITS-1:0]  x_d, x_q;

  assign xprod = XP_W'(dsel_q) * XP_W'(edge_scale_q);
  assign xraw  = xprod[XP_W-1:DW];
  assign x_d   = (xraw > SCALE_W'(W_ONE)) ? W_BITS'(W_ONE) : xraw[W_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (en[2]) x_q <= x_d;
  end

  // stage 3: (1 - x)^2 and 1 + 2x
  logic [W_BITS-1:0] ax;
  logic [2*W_BITS-1:0] aa_full;
  logic [AA_W-1:0]   aa_q;
  logic [T_W-1:0]    t_d, t_q;

  assign ax      = W_BITS'(W_ONE) - x_q;
  assign aa_full = (2*W_BITS)'(ax) * (2*W_BITS)'(ax);
  assign t_d     = T_W'(W_ONE) + {x_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      aa_q <= aa_full[AA_W-1:0];
      t_q  <= t_d;
    end
  end

  // stage 4: weight
  logic [WP_W-1:0]   wprod;
  logic [W_BITS-1:0] w_q;

  assign wprod = WP_W'(aa_q) * WP_W'(t_q);

  always_ff @(posedge clk_i) begin
    if (en[4]) w_q <= wprod[2*W_FRAC +: W_BITS];
  end

  // stage 5: channel products; volume mode keeps rgb and scales alpha only
  logic [CHANNEL_BITS-1:0] ec [NUM_CHAN];
  logic [CHANNEL_BITS-1:0] fc [NUM_CHAN];
  logic [W_BITS-1:0]       wc [NUM_CHAN];
  logic [P_W-1:0]          pa_q [NUM_CHAN];
  logic [P_W-1:0]          pb_q [NUM_CHAN];

  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      ec[k] = edge_color_q[(NUM_CHAN-1-k)*SLOT_W +: CHANNEL_BITS];
      fc[k] = volume_mode_q ? '0 : face_color_q[(NUM_CHAN-1-k)*SLOT_W +: CHANNEL_BITS];
      wc[k] = (volume_mode_q && k != NUM_CHAN - 1) ? W_BITS'(W_ONE) : w_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        pa_q[k] <= P_W'(ec[k]) * P_W'(wc[k]);
        pb_q[k] <= P_W'(fc[k]) * P_W'(W_BITS'(W_ONE) - wc[k]);
      end
    end
  end

  // stage 6: round half up and hold for the output
  logic [S_W-1:0]    sum [NUM_CHAN];
  logic [SLOT_W-1:0] out_q [NUM_CHAN];

  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      sum[k] = S_W'(pa_q[k]) + S_W'(pb_q[k]) + S_W'(W_ONE / 2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      for (int k = 0; k < NUM_CHAN; k++) out_q[k] <= sum[k][W_FRAC +: SLOT_W];
    end
  end

  assign m_axis_tvalid_o = vld_q[NSTG-1];
  for (genvar g = 0; g < NUM_CHAN; g++) begin : g_out
    assign m_axis_tdata_o[g*SLOT_W +: SLOT_W] = out_q[g];
  end

`ifndef SYNTH
  a_x_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (x_q <= W_BITS'(W_ONE)))
    else $error("scaled distance above one");

  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> (w_q <= W_BITS'(W_ONE)))
    else $error("weight above one");

  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[NSTG-1] |-> s_axis_tready_o)
    else $error("input held while output stage empty");

  a_item_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[2] && en[3]) |=> vld_q[3])
    else $error("item lost between stages");

  a_input_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> vld_q[0])
    else $error("accepted item not in first stage");
`endif

endmodule
